// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared widths, command and status codes and control types of the deque
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_PUSH_LEFT  = 3'd0;
    localparam t_cmd CMD_PUSH_RIGHT = 3'd1;
    localparam t_cmd CMD_POP_LEFT   = 3'd2;
    localparam t_cmd CMD_POP_RIGHT  = 3'd3;
    localparam t_cmd CMD_NONE       = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic [CNT_W-1:0] RST_CAPACITY = 8'd128;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic rd;
        logic load;
    } t_ctl;

    // configuration write
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;
        logic                     ends_valid;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         fill_count;
        t_status                  status;
    } t_result;

endpackage

// ===== rtl/cdq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cdq_cmd_if
// command channel: valid/ready handshake with command and push data
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [cdq_pkg::CMD_W-1:0]        command;
    logic signed [cdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== rtl/cdq_res_if.sv =====
// ----------------------------------------------------------------------------
// cdq_res_if
// result channel: valid/ready handshake with end values, flags and status
// ----------------------------------------------------------------------------
interface cdq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [cdq_pkg::DATA_W-1:0] left_value;
    logic signed [cdq_pkg::DATA_W-1:0] right_value;
    logic                              ends_valid;
    logic                              is_empty;
    logic                              is_full;
    logic [cdq_pkg::CNT_W-1:0]         fill_count;
    logic [cdq_pkg::STAT_W-1:0]        status;

    modport source (output valid, output left_value, output right_value,
                    output ends_valid, output is_empty, output is_full,
                    output fill_count, output status, input ready);
    modport sink   (input valid, input left_value, input right_value,
                    input ends_valid, input is_empty, input is_full,
                    input fill_count, input status, output ready);
endinterface

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a ring store with an apb capacity register
// ----------------------------------------------------------------------------
// usage
// - i_cmd carries one command a beat: push left/right, pop left/right or
//   none; every accepted beat gives exactly one beat on o_res showing both
//   end values, empty/full flags, fill count and a status code
// - rejected push (full) or pop (empty) leaves the deque as it was and
//   reports it in status; codes above none act as none
// - sequence: an accepted command is latched, then passes the execute, read
//   and load steps around the store's registered read port; o_res.valid is
//   registered from load, and no new command is taken until load is done
// - a new command is taken while the previous result still waits on o_res;
//   a stalled receiver holds the result and stops the sequencer at load
// - capacity register at address 0; writing it empties the deque
// - reset (i_rst_n low, synchronous) empties the deque, sets capacity to
//   128 and drops o_res.valid; store contents are not cleared
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cdq_cmd_if.sink                        i_cmd,
    cdq_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdq_pkg::ADDR_W-1:0]     paddr,
    input  logic [cdq_pkg::APB_W-1:0]      pwdata,
    output logic [cdq_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);
    import cdq_pkg::*;

    t_ctl             w_ctl;
    t_cfg_wr          w_cfg;
    t_result          w_res;
    logic [CNT_W-1:0] w_capacity;

    assign pready     = 1'b1;
    assign w_cfg.we   = psel && penable && pwrite && !paddr[ADDR_W-1];
    assign w_cfg.data = pwdata[CNT_W-1:0];
    assign prdata     = paddr[ADDR_W-1] ? '0 : APB_W'(w_capacity);

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_ctl       (w_ctl)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_command  (i_cmd.command),
        .i_value    (i_cmd.value),
        .i_cfg      (w_cfg),
        .o_capacity (w_capacity),
        .o_res      (w_res)
    );

    assign o_res.left_value  = w_res.left_value;
    assign o_res.right_value = w_res.right_value;
    assign o_res.ends_valid  = w_res.ends_valid;
    assign o_res.is_empty    = w_res.is_empty;
    assign o_res.is_full     = w_res.is_full;
    assign o_res.fill_count  = w_res.fill_count;
    assign o_res.status      = w_res.status;

endmodule

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept, execute, read ends, load result register
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cdq_pkg::t_ctl o_ctl
);
    import cdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_ctl.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    o_ctl.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_out_valid)
        else $error("result not presented after load");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.latch, o_ctl.exec, o_ctl.rd, o_ctl.load}))
        else $error("more than one datapath step in a cycle");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("stalled result beat dropped");

endmodule

// ===== rtl/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp
// datapath: ring store, head/tail/count registers, capacity, result register
// ----------------------------------------------------------------------------
module cdq_dp #(
    parameter int DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdq_pkg::t_ctl                 i_ctl,
    input  logic [cdq_pkg::CMD_W-1:0]     i_command,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_value,
    input  cdq_pkg::t_cfg_wr              i_cfg,
    output logic [cdq_pkg::CNT_W-1:0]     o_capacity,
    output cdq_pkg::t_result              o_res
);
    import cdq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
    localparam logic [CNT_W-1:0] RST_ECAP =
        (DEPTH < 128) ? CNT_W'(DEPTH) : RST_CAPACITY;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_ecap;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_val;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_rd_l, r_rd_r;
    t_result           r_res;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [CNT_W-1:0]  w_cfg_ecap;
    logic              w_full, w_empty;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i,
                                               input logic [CNT_W-1:0] cap);
        logic [XW-1:0] nx;
        nx = XW'(i) + XW'(1);
        return (nx >= XW'(cap)) ? '0 : nx[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i,
                                               input logic [CNT_W-1:0] cap);
        logic [XW-1:0] cm1;
        cm1 = XW'(cap) - XW'(1);
        return (i == '0 || XW'(i) > XW'(cap)) ? cm1[IW-1:0] : i - IW'(1);
    endfunction

    // zero acts as one, above depth acts as depth
    always_comb begin
        w_cfg_ecap = (i_cfg.data == '0) ? CNT_W'(1) : i_cfg.data;
        if (XW'(w_cfg_ecap) > XW'(DEPTH)) begin
            w_cfg_ecap = CNT_W'(DEPTH);
        end
    end

    assign w_full  = (r_count >= r_ecap);
    assign w_empty = (r_count == '0);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_OK;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        priority if (r_cmd == CMD_PUSH_LEFT || r_cmd == CMD_PUSH_RIGHT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_we    = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (r_cmd == CMD_PUSH_LEFT) begin
                    n_head  = wrap_dec(r_head, r_ecap);
                    w_waddr = n_head;
                end else begin
                    n_tail  = wrap_inc(r_tail, r_ecap);
                end
            end
        end else if (r_cmd == CMD_POP_LEFT || r_cmd == CMD_POP_RIGHT) begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                if (r_cmd == CMD_POP_LEFT) begin
                    n_head = wrap_inc(r_head, r_ecap);
                end else begin
                    n_tail = wrap_dec(r_tail, r_ecap);
                end
            end
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_we) begin
            r_mem[w_waddr] <= r_val;
        end
        if (i_ctl.rd) begin
            r_rd_l <= r_mem[r_head];
            r_rd_r <= r_mem[wrap_dec(r_tail, r_ecap)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= RST_CAPACITY;
            r_ecap  <= RST_ECAP;
        end else if (i_cfg.we) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= i_cfg.data;
            r_ecap  <= w_cfg_ecap;
        end else if (i_ctl.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (i_ctl.exec) begin
            r_status <= n_status;
        end
        if (i_ctl.load) begin
            r_res.left_value  <= w_empty ? '0 : r_rd_l;
            r_res.right_value <= w_empty ? '0 : r_rd_r;
            r_res.ends_valid  <= !w_empty;
            r_res.is_empty    <= w_empty;
            r_res.is_full     <= w_full;
            r_res.fill_count  <= r_count;
            r_res.status      <= r_status;
        end
    end

    assign o_capacity = r_cap;
    assign o_res      = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_ecap)
        else $error("entry count above capacity");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_head) < XW'(r_ecap)) && (XW'(r_tail) < XW'(r_ecap)))
        else $error("ring index outside capacity");

    a_ends_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == r_ecap) |-> r_head == r_tail)
        else $error("head and tail disagree with count");

endmodule

// ===== bench/circular_deque_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_check
// watches the command, result and apb channels of the deque, keeps its own
// copy of the ring, indices, count and capacity, predicts the view that each
// accepted command beat must give, and compares every result beat with the
// oldest prediction field by field
// ----------------------------------------------------------------------------
module circular_deque_check #(
    parameter int DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cdq_cmd_if                         cmd_mon,
    cdq_res_if                         res_mon,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cdq_pkg::ADDR_W-1:0] paddr,
    input  logic [cdq_pkg::APB_W-1:0]  pwdata,
    input  logic                       pready,
    output int                         o_errors,
    output int                         o_pending
);
    import cdq_pkg::*;

    localparam int CAP_REG_INDEX = 0;

    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       fill;
    logic [CNT_W-1:0]  cap_reg;
    t_result           pending_views [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        head_idx  = 0;
        tail_idx  = 0;
        fill      = 0;
        cap_reg   = RST_CAPACITY;
        for (int i = 0; i < DEPTH; i++) begin
            ring[i] = '0;
        end
    end

    function automatic int unsigned usable_depth();
        int unsigned c;
        c = 32'(cap_reg);
        if (c == 0) begin
            c = 1;
        end
        if (c > DEPTH) begin
            c = DEPTH;
        end
        return c;
    endfunction

    function automatic int unsigned step_up(int unsigned i, int unsigned lim);
        return (i + 1 >= lim) ? 0 : i + 1;
    endfunction

    function automatic int unsigned step_down(int unsigned i, int unsigned lim);
        return (i == 0 || i > lim) ? lim - 1 : i - 1;
    endfunction

    function automatic t_result apply_command(t_cmd c, logic [DATA_W-1:0] v);
        t_result     r;
        int unsigned lim;
        lim      = usable_depth();
        r.status = ST_OK;
        case (c)
            CMD_PUSH_LEFT, CMD_PUSH_RIGHT: begin
                if (fill >= lim) begin
                    r.status = ST_FULL;
                end else if (c == CMD_PUSH_LEFT) begin
                    head_idx = step_down(head_idx, lim);
                    ring[head_idx % DEPTH] = v;
                    fill++;
                end else begin
                    ring[tail_idx % DEPTH] = v;
                    tail_idx = step_up(tail_idx, lim);
                    fill++;
                end
            end
            CMD_POP_LEFT, CMD_POP_RIGHT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (c == CMD_POP_LEFT) begin
                    head_idx = step_up(head_idx, lim);
                    fill--;
                end else begin
                    tail_idx = step_down(tail_idx, lim);
                    fill--;
                end
            end
            default: begin
            end
        endcase
        r.left_value  = '0;
        r.right_value = '0;
        if (fill != 0) begin
            r.left_value  = ring[head_idx % DEPTH];
            r.right_value = ring[step_down(tail_idx, lim) % DEPTH];
        end
        r.ends_valid = (fill != 0);
        r.is_empty   = (fill == 0);
        r.is_full    = (fill >= lim);
        r.fill_count = fill[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string fname, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            cap_reg  = RST_CAPACITY;
            pending_views.delete();
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                if (pending_views.size() == 0) begin
                    $error("result beat with no command waiting");
                    o_errors++;
                end else begin
                    want = pending_views.pop_front();
                    check_field("left_value", want.left_value, res_mon.left_value);
                    check_field("right_value", want.right_value, res_mon.right_value);
                    check_field("ends_valid", DATA_W'(want.ends_valid),
                                DATA_W'(res_mon.ends_valid));
                    check_field("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(res_mon.is_empty));
                    check_field("is_full", DATA_W'(want.is_full),
                                DATA_W'(res_mon.is_full));
                    check_field("fill_count", DATA_W'(want.fill_count),
                                DATA_W'(res_mon.fill_count));
                    check_field("status", DATA_W'(want.status),
                                DATA_W'(res_mon.status));
                end
            end
            if (cmd_mon.valid && cmd_mon.ready) begin
                pending_views.push_back(apply_command(cmd_mon.command, cmd_mon.value));
            end
            if (psel && penable && pwrite && pready) begin
                if ((paddr >> 2) == CAP_REG_INDEX) begin
                    cap_reg  = pwdata[CNT_W-1:0];
                    head_idx = 0;
                    tail_idx = 0;
                    fill     = 0;
                end
            end
        end
        o_pending = pending_views.size();
    end

endmodule

// ===== bench/circular_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// drives the deque with directed corner commands and then random push/pop
// runs under several capacity settings, with random gaps on the command side
// and random stalls on the result side; the checker beside the block
// predicts and compares, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module circular_deque_tb;
    import cdq_pkg::*;

    localparam int   DEPTH          = 128;
    localparam t_cmd CMD_SPARE_LOW  = 3'd5;
    localparam t_cmd CMD_SPARE_HIGH = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED   = 3'd4;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    int                error_total;
    int                waiting_views;

    int cmd_stretch;
    bit cmd_calm;
    int rdy_stretch;
    bit rdy_calm;

    cdq_cmd_if cmd_if();
    cdq_res_if res_if();

    circular_deque #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    circular_deque_check #(.DEPTH(DEPTH)) checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cmd_mon   (cmd_if),
        .res_mon   (res_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (error_total),
        .o_pending (waiting_views)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("circular_deque_tb: done, errors");
        $finish;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd pick_command(int push_pct);
        if ($urandom_range(0, 99) < 5) begin
            return t_cmd'($urandom_range(CMD_NONE, CMD_SPARE_HIGH));
        end
        if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? CMD_PUSH_RIGHT : CMD_PUSH_LEFT;
        end
        return $urandom_range(0, 1) ? CMD_POP_RIGHT : CMD_POP_LEFT;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_cmd(t_cmd c, logic [DATA_W-1:0] v);
        int gap;
        if (cmd_stretch == 0) begin
            cmd_stretch = $urandom_range(10, 60);
            cmd_calm    = ($urandom_range(0, 2) == 0);
        end
        cmd_stretch--;
        gap = draw_wait(cmd_calm);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= c;
        cmd_if.value   <= v;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [APB_W-1:0] data);
        cmd_if.valid <= 1'b0;
        while (waiting_views != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_items(int n, int lim);
        int seg;
        int push_pct;
        seg      = 0;
        push_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (seg == 0) begin
                seg = $urandom_range(1, lim + 16);
                case ($urandom_range(0, 2))
                    0:       push_pct = 95;
                    1:       push_pct = 5;
                    default: push_pct = 50;
                endcase
            end
            seg--;
            send_cmd(pick_command(push_pct), pick_value());
        end
    endtask

    task automatic run_phase(logic [APB_W-1:0] cap_word, int n);
        int lim;
        lim = int'(cap_word[CNT_W-1:0]);
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > DEPTH) begin
            lim = DEPTH;
        end
        apb_write(ADDR_CAPACITY, cap_word);
        run_items(n, lim);
    endtask

    // result side: a random stall before each beat, none in calm stretches
    initial begin
        int stall;
        res_if.ready = 1'b0;
        rdy_stretch  = 0;
        rdy_calm     = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rdy_stretch == 0) begin
                rdy_stretch = $urandom_range(10, 60);
                rdy_calm    = ($urandom_range(0, 2) == 0);
            end
            rdy_stretch--;
            stall = draw_wait(rdy_calm);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            @(negedge i_clk);
        end
    end

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_NONE;
        cmd_if.value   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_stretch    = 0;
        cmd_calm       = 1'b0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset capacity: empty pops, spare codes, extreme values at both ends
        send_cmd(CMD_POP_LEFT, 32'h0);
        send_cmd(CMD_POP_RIGHT, 32'hFFFF_FFFF);
        send_cmd(CMD_NONE, 32'h1234_5678);
        send_cmd(CMD_SPARE_LOW, 32'h0);
        send_cmd(CMD_SPARE_HIGH, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_LEFT, 32'h7FFF_FFFF);
        send_cmd(CMD_PUSH_RIGHT, 32'h8000_0000);
        send_cmd(CMD_PUSH_LEFT, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_RIGHT, 32'h0000_0000);
        send_cmd(CMD_NONE, 32'h0);
        send_cmd(CMD_POP_LEFT, 32'h0);
        send_cmd(CMD_POP_RIGHT, 32'h0);
        send_cmd(CMD_POP_RIGHT, 32'h0);
        send_cmd(CMD_POP_LEFT, 32'h0);
        send_cmd(CMD_POP_RIGHT, 32'h0);

        // single entry: full right after one push
        apb_write(ADDR_CAPACITY, 32'd1);
        send_cmd(CMD_PUSH_RIGHT, 32'h1234_5678);
        send_cmd(CMD_PUSH_LEFT, 32'h5555_AAAA);
        send_cmd(CMD_PUSH_RIGHT, 32'h5555_AAAA);
        send_cmd(CMD_POP_LEFT, 32'h0);
        send_cmd(CMD_POP_LEFT, 32'h0);

        // zero capacity acts as one
        apb_write(ADDR_CAPACITY, 32'd0);
        send_cmd(CMD_PUSH_LEFT, 32'hAAAA_5555);
        send_cmd(CMD_PUSH_LEFT, 32'h0F0F_F0F0);
        send_cmd(CMD_POP_RIGHT, 32'h0);

        run_phase(32'd128, 200);
        run_phase(32'd2, 30);
        run_phase(32'd3, 30);
        // write to an unused address must leave the deque as it is
        apb_write(ADDR_UNUSED, 32'd1);
        run_items(20, 3);
        run_phase(32'd255, 200);
        run_phase(32'hA5A5_5A05, 30);
        run_phase(32'd1, 30);
        run_phase(32'd200, 180);
        run_phase(32'd17, 40);
        run_phase(32'(1 + $urandom_range(0, DEPTH - 1)), 60);
        run_phase(32'd0, 20);
        run_phase(32'd64, 80);

        cmd_if.valid <= 1'b0;
        while (waiting_views != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_total == 0) begin
            $display("circular_deque_tb: done, clean");
        end else begin
            $display("circular_deque_tb: done, errors");
        end
        $finish;
    end

endmodule
